// ----- rtl/pq_pkg.sv -----
package pq_pkg;

  // Sizes of the block
  localparam int PRIORITY_LEVELS = 8;
  localparam int QUEUE_DEPTH     = 16;
  localparam int STACK_DEPTH     = 16;
  localparam int TAG_WIDTH       = 16;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int PRIO_W  = 4;
  localparam int STAT_W  = 3;
  localparam int MOVED_W = 5;
  localparam int MOVED_MAX = (1 << MOVED_W) - 1;

  // Derived widths
  localparam int LVL_W   = $clog2(PRIORITY_LEVELS);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QADDR_W = $clog2(PRIORITY_LEVELS * QUEUE_DEPTH);
  localparam int QMEM_D  = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int SPTR_W  = $clog2(STACK_DEPTH);
  localparam int SCNT_W  = $clog2(STACK_DEPTH + 1);

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Stream word widths
  localparam int S_TDATA_W = ((CMD_W + PRIO_W + TAG_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((STAT_W + 1 + TAG_WIDTH + MOVED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PUSH  = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_DROPPED = 3'd3,
    STAT_BADPRIO = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_DRAIN
  } state_t;

  // Classified command, front -> back
  typedef struct packed {
    op_t                  op;
    logic                 prio_ok;
    logic [LVL_W-1:0]     lvl;
    logic [TAG_WIDTH-1:0] tag;
  } cmd_t;

  // Result word, first field in the high bits
  typedef struct packed {
    logic [MOVED_W-1:0]   moved;
    logic [TAG_WIDTH-1:0] out_tag;
    logic                 tag_valid;
    status_t              status;
  } res_t;

  function automatic logic [QADDR_W-1:0] q_addr(input logic [LVL_W-1:0] lvl,
                                                input logic [QPTR_W-1:0] ptr);
    q_addr = QADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
  endfunction

  function automatic logic [QPTR_W-1:0] q_inc(input logic [QPTR_W-1:0] ptr);
    if (int'(ptr) == QUEUE_DEPTH - 1) begin
      q_inc = '0;
    end else begin
      q_inc = ptr + QPTR_W'(1);
    end
  endfunction

endpackage

// ----- rtl/pq_front.sv -----
module pq_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pq_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                              cmd_valid,
  output pq_pkg::cmd_t                      cmd,
  input  logic                              cmd_take
);

  pq_pkg::cmd_t                   cq [pq_pkg::CQ_DEPTH];
  logic [pq_pkg::CQ_PTR_W-1:0]    wr_ptr;
  logic [pq_pkg::CQ_PTR_W-1:0]    rd_ptr;
  logic [pq_pkg::CQ_CNT_W-1:0]    cq_cnt;
  logic                           push;
  logic                           pop;
  logic [pq_pkg::PRIO_W-1:0]      prio;
  pq_pkg::cmd_t                   cls;

  // classify incoming word
  always_comb begin
    prio        = s_tdata[pq_pkg::CMD_W +: pq_pkg::PRIO_W];
    cls.op      = pq_pkg::op_t'(s_tdata[pq_pkg::CMD_W-1:0]);
    cls.tag     = s_tdata[pq_pkg::CMD_W + pq_pkg::PRIO_W +: pq_pkg::TAG_WIDTH];
    cls.prio_ok = (int'(prio) >= 1) && (int'(prio) <= pq_pkg::PRIORITY_LEVELS);
    cls.lvl     = cls.prio_ok ? pq_pkg::LVL_W'(prio - pq_pkg::PRIO_W'(1)) : '0;
  end

  assign s_tready  = (int'(cq_cnt) != pq_pkg::CQ_DEPTH);
  assign cmd_valid = (cq_cnt != '0);
  assign cmd       = cq[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      cq[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cq_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == pq_pkg::CQ_DEPTH - 1) ? '0 : wr_ptr + pq_pkg::CQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == pq_pkg::CQ_DEPTH - 1) ? '0 : rd_ptr + pq_pkg::CQ_PTR_W'(1);
      end
      if (push && !pop) begin
        cq_cnt <= cq_cnt + pq_pkg::CQ_CNT_W'(1);
      end else if (pop && !push) begin
        cq_cnt <= cq_cnt - pq_pkg::CQ_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/pq_back.sv -----
module pq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  pq_pkg::cmd_t                      cmd,
  output logic                              cmd_take,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pq_pkg::M_TDATA_W-1:0]      m_tdata
);

  pq_pkg::state_t                 state;
  pq_pkg::state_t                 state_next;

  logic [pq_pkg::QPTR_W-1:0]      heads  [pq_pkg::PRIORITY_LEVELS];
  logic [pq_pkg::QPTR_W-1:0]      tails  [pq_pkg::PRIORITY_LEVELS];
  logic [pq_pkg::QCNT_W-1:0]      counts [pq_pkg::PRIORITY_LEVELS];

  logic [pq_pkg::TAG_WIDTH-1:0]   qmem   [pq_pkg::QMEM_D];
  logic [pq_pkg::TAG_WIDTH-1:0]   rd_data;

  logic [pq_pkg::TAG_WIDTH-1:0]   stk_tag [pq_pkg::STACK_DEPTH];
  logic [pq_pkg::LVL_W-1:0]       stk_lvl [pq_pkg::STACK_DEPTH];
  logic [pq_pkg::SCNT_W-1:0]      stk_cnt;
  logic [pq_pkg::SCNT_W-1:0]      stk_cnt_next;
  logic [pq_pkg::SPTR_W-1:0]      stk_top;

  logic [pq_pkg::MOVED_W-1:0]     moved;
  logic [pq_pkg::MOVED_W-1:0]     moved_next;
  logic                           dropped;
  logic                           dropped_next;

  logic                           res_valid;
  pq_pkg::res_t                   res;
  pq_pkg::res_t                   res_new;
  logic                           res_load;
  logic                           slot_free;

  logic                           q_put;
  logic [pq_pkg::LVL_W-1:0]       put_lvl;
  logic [pq_pkg::TAG_WIDTH-1:0]   put_tag;
  logic                           put_full;
  logic                           q_get;
  logic                           stk_push;

  assign slot_free = !res_valid || m_tready;
  assign stk_top   = pq_pkg::SPTR_W'(stk_cnt - pq_pkg::SCNT_W'(1));
  assign put_lvl   = (state == pq_pkg::S_DRAIN) ? stk_lvl[stk_top] : cmd.lvl;
  assign put_tag   = (state == pq_pkg::S_DRAIN) ? stk_tag[stk_top] : cmd.tag;
  assign put_full  = (int'(counts[put_lvl]) == pq_pkg::QUEUE_DEPTH);

  always_comb begin
    state_next        = state;
    stk_cnt_next      = stk_cnt;
    moved_next        = moved;
    dropped_next      = dropped;
    cmd_take          = 1'b0;
    res_load          = 1'b0;
    res_new.status    = pq_pkg::STAT_OK;
    res_new.tag_valid = 1'b0;
    res_new.out_tag   = '0;
    res_new.moved     = '0;
    q_put             = 1'b0;
    q_get             = 1'b0;
    stk_push          = 1'b0;
    case (state)
      pq_pkg::S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_take = 1'b1;
          case (cmd.op)
            pq_pkg::OP_ENQ: begin
              res_load = 1'b1;
              if (!cmd.prio_ok) begin
                res_new.status = pq_pkg::STAT_BADPRIO;
              end else if (put_full) begin
                res_new.status = pq_pkg::STAT_FULL;
              end else begin
                q_put = 1'b1;
              end
            end
            pq_pkg::OP_DEQ: begin
              if (!cmd.prio_ok) begin
                res_load       = 1'b1;
                res_new.status = pq_pkg::STAT_BADPRIO;
              end else if (counts[cmd.lvl] == '0) begin
                res_load       = 1'b1;
                res_new.status = pq_pkg::STAT_EMPTY;
              end else begin
                q_get      = 1'b1;
                state_next = pq_pkg::S_DEQ;
              end
            end
            pq_pkg::OP_PUSH: begin
              res_load = 1'b1;
              if (!cmd.prio_ok) begin
                res_new.status = pq_pkg::STAT_BADPRIO;
              end else if (int'(stk_cnt) == pq_pkg::STACK_DEPTH) begin
                res_new.status = pq_pkg::STAT_FULL;
              end else begin
                stk_push     = 1'b1;
                stk_cnt_next = stk_cnt + pq_pkg::SCNT_W'(1);
              end
            end
            default: begin
              moved_next   = '0;
              dropped_next = 1'b0;
              state_next   = pq_pkg::S_DRAIN;
            end
          endcase
        end
      end
      pq_pkg::S_DEQ: begin
        // read data from the queue memory lands here
        res_load          = 1'b1;
        res_new.tag_valid = 1'b1;
        res_new.out_tag   = rd_data;
        state_next        = pq_pkg::S_IDLE;
      end
      pq_pkg::S_DRAIN: begin
        if (stk_cnt == '0) begin
          res_load       = 1'b1;
          res_new.status = dropped ? pq_pkg::STAT_DROPPED : pq_pkg::STAT_OK;
          res_new.moved  = moved;
          state_next     = pq_pkg::S_IDLE;
        end else begin
          stk_cnt_next = stk_cnt - pq_pkg::SCNT_W'(1);
          if (put_full) begin
            dropped_next = 1'b1;
          end else begin
            q_put = 1'b1;
            if (int'(moved) != pq_pkg::MOVED_MAX) begin
              moved_next = moved + pq_pkg::MOVED_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = pq_pkg::S_IDLE;
      end
    endcase
  end

  // queue memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_put) begin
      qmem[pq_pkg::q_addr(put_lvl, tails[put_lvl])] <= put_tag;
    end
    if (q_get) begin
      rd_data <= qmem[pq_pkg::q_addr(cmd.lvl, heads[cmd.lvl])];
    end
  end

  // staging stack payload
  always_ff @(posedge clk) begin
    if (stk_push) begin
      stk_tag[pq_pkg::SPTR_W'(stk_cnt)] <= cmd.tag;
      stk_lvl[pq_pkg::SPTR_W'(stk_cnt)] <= cmd.lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pq_pkg::PRIORITY_LEVELS; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (q_put) begin
        tails[put_lvl]  <= pq_pkg::q_inc(tails[put_lvl]);
        counts[put_lvl] <= counts[put_lvl] + pq_pkg::QCNT_W'(1);
      end
      if (q_get) begin
        heads[cmd.lvl]  <= pq_pkg::q_inc(heads[cmd.lvl]);
        counts[cmd.lvl] <= counts[cmd.lvl] - pq_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pq_pkg::S_IDLE;
      stk_cnt   <= '0;
      moved     <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      stk_cnt <= stk_cnt_next;
      moved   <= moved_next;
      dropped <= dropped_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_new;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {{(pq_pkg::M_TDATA_W - $bits(pq_pkg::res_t)){1'b0}}, res};

  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || m_tready))
    else $error("result overwritten before taken");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == pq_pkg::S_IDLE))
    else $error("command taken while busy");

  a_deq_result: assert property (@(posedge clk) disable iff (rst)
    (state == pq_pkg::S_DEQ) |=> (res_valid && res.tag_valid))
    else $error("dequeue gave no tag");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == pq_pkg::S_DRAIN && res_load) |=> (stk_cnt == '0))
    else $error("stack not empty after drain");

  a_stk_bound: assert property (@(posedge clk) disable iff (rst)
    int'(stk_cnt) <= pq_pkg::STACK_DEPTH)
    else $error("stack count out of range");

endmodule

// ----- rtl/priority_queues_with_drain_stack_unit.sv -----
// Eight FIFO queues of 16-bit tags, one per priority 1..8, 16 deep each, plus a
// 16-entry staging stack of (tag, priority) pairs. Each input word is one
// command; each command returns exactly one result word. Enqueue, push and any
// rejected command (bad priority, full, empty) has its result registered as the
// back end takes it. Dequeue passes through the S_DEQ state first, since the
// queue memory read is registered. Drain picks up the command, then moves one
// stack entry per cycle, top first, then posts the result. Those per-entry
// memory writes set the rate. A two-word command queue sits between input and
// execution, so input words are taken while a result waits on the output.
// Queue memory and stack payload are not cleared at reset; only pointers,
// counts and control state are, so no clearing pass is needed.
module priority_queues_with_drain_stack_unit (
  input  logic                              clk,
  input  logic                              rst,
  // command words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [1:0] cmd, [5:2] prio_level, [21:6] name_tag, [23:22] zero
  input  logic [pq_pkg::S_TDATA_W-1:0]      s_tdata,
  // result words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] status, [3] tag_valid, [19:4] out_tag, [24:20] moved_count,
  // [31:25] zero
  output logic [pq_pkg::M_TDATA_W-1:0]      m_tdata
);

  // classified command handed from front to back
  pq_pkg::cmd_t cmd;
  logic         cmd_valid;
  logic         cmd_take;

  // front: decode, range-check priority, buffer
  pq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: queues, stack, drain sequencer, result register
  pq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
